// File: hw/rtl/assert_macros.svh
// Assertion macros for the deframer RTL.
// No dependencies; pulled in by the top level, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SWFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deframer assertion failed");

// Check a property at every clock edge, reset included.
`define SWFD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("deframer assertion failed during or after reset");

`endif

// File: hw/rtl/swfd_pkg.sv
// Shared types, codes and constants of the sync word frame deframer.
// No dependencies; used by the parser, output stage and top level.
package swfd_pkg;

   localparam int unsigned TIMER_BITS_DEFAULT = 16;

   localparam logic [7:0]  SYNC_FIRST        = 8'h55;
   localparam logic [7:0]  SYNC_SECOND       = 8'hAA;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd100;
   localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd250;

   localparam logic        CSR_TIMEOUT_TICKS = 1'b0;
   localparam logic        CSR_MAX_PAYLOAD   = 1'b1;

   localparam logic        MODE_BYTE = 1'b0;
   localparam logic        MODE_TICK = 1'b1;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD_SUM = 2'd2,
      KIND_ABORT   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  max_payload;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_out;
      logic [7:0]  port;
      logic [7:0]  length;
      logic        last;
   } rsp_type;

endpackage

// File: hw/rtl/sync_word_frame_deframer.sv
// Sync word frame deframer, top level: config registers, parser, result stage.
// Depends on swfd_pkg, swfd_parser, swfd_out_reg and assert_macros.svh.
// Results are registered in the result stage before they show on rsp_.
// Throughput: one input item per cycle while req_tready is high; the single parser state update sets it.
// Backpressure: a skid stage keeps req_tready high while one result waits.
// Reset: synchronous, active high; parser back to hunting, registers to defaults.
`include "assert_macros.svh"

module sync_word_frame_deframer #(
   parameter int unsigned TIMER_BITS = swfd_pkg::TIMER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] byte_out, [15:8] port, [23:16] length
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);

   swfd_pkg::cfg_type cfg_ff;
   swfd_pkg::rsp_type res;
   swfd_pkg::rsp_type out_data;
   logic              res_valid;
   logic              space;
   logic              req_xfer;

   assign csr_ready  = 1'b1;
   assign req_tready = space;
   assign req_xfer   = req_tvalid && space;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= swfd_pkg::TIMEOUT_RESET;
         cfg_ff.max_payload   <= swfd_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_valid) begin
         case (csr_index[0])
            swfd_pkg::CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data;
            swfd_pkg::CSR_MAX_PAYLOAD:   cfg_ff.max_payload   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   swfd_parser #(
      .TIMER_BITS (TIMER_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (req_xfer),
      .item_mode  (req_tuser[0]),
      .item_data  (req_tdata),
      .res_valid  (res_valid),
      .res        (res)
   );

   swfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {out_data.length, out_data.port, out_data.byte_out};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

   `SWFD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)
   `SWFD_ASSERT(a_stall_means_full, clock, reset, !req_tready |-> rsp_tvalid)
   `SWFD_ASSERT(a_tick_gives_verdict, clock, reset,
      req_tvalid && req_tready && req_tuser[0] && !rsp_tvalid |=> !rsp_tvalid || rsp_tlast)

endmodule

// File: hw/rtl/swfd_parser.sv
// Frame parser: sync hunt, header capture, checksum and timeout tracking.
// Depends on swfd_pkg for the configuration and result types.
module swfd_parser #(
   parameter int unsigned TIMER_BITS = swfd_pkg::TIMER_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  swfd_pkg::cfg_type cfg,
   input  logic              item_valid,
   input  logic              item_mode,
   input  logic [7:0]        item_data,
   output logic              res_valid,
   output swfd_pkg::rsp_type res
);

   localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   typedef enum logic [2:0] {
      PH_HUNT0   = 3'd0,
      PH_HUNT1   = 3'd1,
      PH_PORT    = 3'd2,
      PH_LEN     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            port_ff, port_in;
   logic [7:0]            length_ff, length_in;
   logic [7:0]            count_ff, count_in;
   logic [7:0]            sum_ff, sum_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;

   logic [TIMER_BITS-1:0] timer_inc;
   logic [7:0]            count_inc;
   logic [7:0]            sum_add;
   logic                  in_frame;
   logic                  started;

   always_comb begin
      timer_inc = (timer_ff == {TIMER_BITS{1'b1}}) ? timer_ff : timer_ff + 1'b1;
      count_inc = count_ff + 8'd1;
      sum_add   = sum_ff + item_data;
      in_frame  = (phase_ff == PH_HUNT1) || (phase_ff == PH_PORT) ||
                  (phase_ff == PH_LEN) || (phase_ff == PH_PAYLOAD) ||
                  (phase_ff == PH_CHECK);
      started   = (phase_ff == PH_PORT) || (phase_ff == PH_LEN) ||
                  (phase_ff == PH_PAYLOAD) || (phase_ff == PH_CHECK);

      phase_in  = phase_ff;
      port_in   = port_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      timer_in  = timer_ff;
      res_valid = 1'b0;
      res.kind     = swfd_pkg::KIND_PAYLOAD;
      res.byte_out = 8'd0;
      res.port     = port_ff;
      res.length   = length_ff;
      res.last     = 1'b0;

      if (item_valid) begin
         if (item_mode == swfd_pkg::MODE_TICK) begin
            if (!in_frame) begin
               phase_in = PH_HUNT0;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
               if (CMP_W'(timer_inc) > CMP_W'(cfg.timeout_ticks)) begin
                  phase_in = PH_HUNT0;
                  timer_in = '0;
                  if (started) begin
                     res_valid = 1'b1;
                     res.kind  = swfd_pkg::KIND_ABORT;
                     res.last  = 1'b1;
                  end
               end
            end
         end else begin
            case (phase_ff)
               PH_HUNT1: begin
                  if (item_data == swfd_pkg::SYNC_SECOND) begin
                     phase_in = PH_PORT;
                  end else if (item_data != swfd_pkg::SYNC_FIRST) begin
                     phase_in = PH_HUNT0;
                     timer_in = '0;
                  end
               end
               PH_PORT: begin
                  port_in  = item_data;
                  sum_in   = item_data;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  if (item_data > cfg.max_payload) begin
                     phase_in = PH_HUNT0;
                     timer_in = '0;
                  end else begin
                     length_in = item_data;
                     count_in  = 8'd0;
                     sum_in    = sum_add;
                     phase_in  = (item_data == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  count_in     = count_inc;
                  sum_in       = sum_add;
                  if (count_inc >= length_ff) begin
                     phase_in = PH_CHECK;
                  end
                  res_valid    = 1'b1;
                  res.byte_out = item_data;
               end
               PH_CHECK: begin
                  phase_in  = PH_HUNT0;
                  timer_in  = '0;
                  res_valid = 1'b1;
                  res.kind  = (sum_ff == item_data) ? swfd_pkg::KIND_GOOD
                                                    : swfd_pkg::KIND_BAD_SUM;
                  res.last  = 1'b1;
               end
               default: begin
                  timer_in = '0;
                  phase_in = (item_data == swfd_pkg::SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT0;
         port_ff   <= 8'd0;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
         sum_ff    <= 8'd0;
         timer_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         port_ff   <= port_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

// File: hw/rtl/swfd_out_reg.sv
// Result register with a skid stage between parser and result channel.
// Depends on swfd_pkg for the result type.
module swfd_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swfd_pkg::rsp_type push_data,
   output logic              space,
   output logic              out_valid,
   input  logic              out_ready,
   output swfd_pkg::rsp_type out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   swfd_pkg::rsp_type main_data_ff, main_data_in;
   swfd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   always_comb begin
      pop           = main_valid_ff && out_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_in = push;
         main_data_in  = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule
